/* hw/rtl/sirs_pkg.sv */
// Shared types for the stable insertion record sorter.
// Holds the record layout and the cell operation codes; no dependencies.
`timescale 1ns / 1ps

package sirs_pkg;

   // One stored record: sort key plus raw payload
   typedef struct packed {
      logic [31:0] score;
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [63:0] text_low;
      logic [63:0] text_high;
   } record_type;

   // Operation that every cell of the row performs in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_EMIT   = 2'd2
   } cell_op_type;

endpackage

/* hw/rtl/sirs_cell.sv */
// One slot of the sorted record row: compare against the incoming key and shift.
// Depends on sirs_pkg for the record layout and the operation codes.
`timescale 1ns / 1ps

module sirs_cell
   import sirs_pkg::*;
(
   input  logic        clock,
   input  cell_op_type op,
   input  logic        occupied,
   input  record_type  new_rec,
   input  logic        prev_flag,
   input  record_type  prev_rec,
   input  record_type  next_rec,
   output logic        flag,
   output record_type  rec
);

   record_type rec_ff;
   record_type rec_in;

   // Flag this slot when it is free or holds a strictly greater key
   assign flag = !occupied || (rec_ff.score > new_rec.score);
   assign rec  = rec_ff;

   // Choose the next content: shift up, take the new beat, shift down, or hold
   always_comb begin
      rec_in = rec_ff;
      unique case (op)
         CELL_INSERT: begin
            if (prev_flag) begin
               rec_in = prev_rec;
            end else if (flag) begin
               rec_in = new_rec;
            end
         end
         CELL_EMIT: begin
            rec_in = next_rec;
         end
         CELL_HOLD: begin
            rec_in = rec_ff;
         end
         default: begin
            rec_in = rec_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

/* hw/rtl/stable_insertion_record_sorter.sv */
// A record is inserted at the edge that accepts it, one record per cycle while idle.
// A beat marked last is inserted too; the first result follows in the next cycle and
// the held records stream out one per cycle while busy is high.
// During emission the row shifts one slot towards cell 0 a cycle.
// Reset clears the fill count, the overflow flag and the control state; slot
// contents are undefined until written. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module stable_insertion_record_sorter
   import sirs_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_score,
   input  logic [31:0] req_data_word0,
   input  logic [31:0] req_data_word1,
   input  logic [31:0] req_data_word2,
   input  logic [63:0] req_text_low,
   input  logic [63:0] req_text_high,
   input  logic        req_last_item,
   output logic        rsp_strobe,
   output logic [31:0] rsp_sorted_score,
   output logic [31:0] rsp_out_word0,
   output logic [31:0] rsp_out_word1,
   output logic [31:0] rsp_out_word2,
   output logic [63:0] rsp_out_text_low,
   output logic [63:0] rsp_out_text_high,
   output logic        rsp_end_of_run,
   output logic        rsp_overflowed
);

   localparam int CntW = $clog2(CAPACITY + 1);

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } state_type;

   state_type   state_ff;
   logic [CntW-1:0] count_ff;
   logic        overflow_ff;

   logic        accept;
   logic        full;
   cell_op_type op;
   record_type  new_rec;
   record_type  cell_rec [CAPACITY];
   logic        cell_flag [CAPACITY];

   assign accept = start && (state_ff == ST_IDLE);
   assign full   = (count_ff == CntW'(CAPACITY));

   // Pack the incoming beat
   always_comb begin
      new_rec.score     = req_score;
      new_rec.word0     = req_data_word0;
      new_rec.word1     = req_data_word1;
      new_rec.word2     = req_data_word2;
      new_rec.text_low  = req_text_low;
      new_rec.text_high = req_text_high;
   end

   // Drive the row: insert on an accepted beat with room, shift out while emitting
   always_comb begin
      if (state_ff == ST_EMIT) begin
         op = CELL_EMIT;
      end else if (accept && !full) begin
         op = CELL_INSERT;
      end else begin
         op = CELL_HOLD;
      end
   end

   // Row of cells, slot 0 holding the smallest key
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic       prev_flag;
      record_type prev_rec;
      record_type next_rec;
      logic       occupied;

      assign occupied = (count_ff > CntW'(i));

      if (i == 0) begin : g_first
         assign prev_flag = 1'b0;
         assign prev_rec  = new_rec;
      end else begin : g_rest
         assign prev_flag = cell_flag[i-1];
         assign prev_rec  = cell_rec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_rec = cell_rec[i];
      end else begin : g_inner
         assign next_rec = cell_rec[i+1];
      end

      sirs_cell u_cell (
         .clock     (clock),
         .op        (op),
         .occupied  (occupied),
         .new_rec   (new_rec),
         .prev_flag (prev_flag),
         .prev_rec  (prev_rec),
         .next_rec  (next_rec),
         .flag      (cell_flag[i]),
         .rec       (cell_rec[i])
      );
   end

   // Hold the fill count, overflow flag and emission state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (full) begin
                     overflow_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + CntW'(1);
                  end
                  if (req_last_item) begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               count_ff <= count_ff - CntW'(1);
               if (count_ff == CntW'(1)) begin
                  state_ff    <= ST_IDLE;
                  overflow_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Present slot 0 as the result beat
   assign busy              = (state_ff == ST_EMIT);
   assign rsp_strobe        = (state_ff == ST_EMIT);
   assign rsp_sorted_score  = cell_rec[0].score;
   assign rsp_out_word0     = cell_rec[0].word0;
   assign rsp_out_word1     = cell_rec[0].word1;
   assign rsp_out_word2     = cell_rec[0].word2;
   assign rsp_out_text_low  = cell_rec[0].text_low;
   assign rsp_out_text_high = cell_rec[0].text_high;
   assign rsp_end_of_run    = (count_ff == CntW'(1));
   assign rsp_overflowed    = overflow_ff;

endmodule

/* hw/rtl/sirs_checker.sv */
// Port-level checks for the stable insertion record sorter, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module sirs_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_last_item,
   input logic        rsp_strobe,
   input logic [31:0] rsp_sorted_score,
   input logic        rsp_end_of_run,
   input logic        rsp_overflowed
);

   // A result beat only appears while the block is busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result beat outside emission");

   // A beat marked last starts emission in the next cycle
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_item) |=> rsp_strobe)
      else $error("emission did not follow last beat");

   // The final result releases the block
   a_end_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_end_of_run) |=> !busy)
      else $error("still busy after end of run");

   // Scores never fall within a run
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_end_of_run) |=>
         (rsp_strobe && (rsp_sorted_score >= $past(rsp_sorted_score))))
      else $error("scores out of order");

   // The overflow mark is the same on every beat of a run
   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_end_of_run) |=> (rsp_overflowed == $past(rsp_overflowed)))
      else $error("overflow mark changed within a run");

endmodule

bind stable_insertion_record_sorter sirs_checker u_sirs_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_last_item    (req_last_item),
   .rsp_strobe       (rsp_strobe),
   .rsp_sorted_score (rsp_sorted_score),
   .rsp_end_of_run   (rsp_end_of_run),
   .rsp_overflowed   (rsp_overflowed)
);
